### rtl/gbte_pkg.sv
package gbte_pkg;

    localparam int DEPTH    = 1024;
    localparam int VIEW_LEN = 10;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = 11;
    localparam int CHAR_W = 8;
    localparam int VW_W   = $clog2(VIEW_LEN + 1);
    localparam int CMP_W  = (LEN_W > CNT_W) ? LEN_W : CNT_W;

    typedef enum logic [1:0] {
        KIND_INSERT     = 2'd0,
        KIND_DELETE     = 2'd1,
        KIND_MOVE_LEFT  = 2'd2,
        KIND_MOVE_RIGHT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  char_in;
        logic [CNT_W-1:0]   count;
    } t_in;

    typedef struct packed {
        logic               accepted;
        logic [CNT_W-1:0]   deleted;
        logic [CHAR_W-1:0]  char_out;
        logic               has_char;
        logic               last;
    } t_out;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [CHAR_W-1:0]  wdata;
    } t_ram_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MREAD,
        ST_MWRITE,
        ST_VSTART,
        ST_VREAD,
        ST_VPUT,
        ST_DONE
    } t_state;

endpackage

### rtl/gap_buffer_text_editor.sv
// Channel  Dir  Payload  Handshake
// in       in   t_in     i_in_valid  / o_in_ready
// out      out  t_out    o_out_valid / i_out_ready
//
// Insert and delete go straight to ST_DONE. A move of n positions copies n
// characters across the gap and then reads out up to v view characters; the
// single-port text memory takes one read and one write per character copied.
// Reset is synchronous, active low; it clears the lengths, the FSM and o_out_valid.
// Results sit in an output register, so a new command is taken while the
// previous result waits; a stalled output stalls the view sequence.
module gap_buffer_text_editor
    import gbte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_left, r_right;
    logic [LEN_W-1:0]   r_n;
    logic               r_dir_right;
    logic [ADDR_W-1:0]  r_vaddr;
    logic [VW_W-1:0]    r_vcnt;
    t_out               r_res;
    t_out               r_out;
    logic               r_out_valid;

    t_ram_req           ram_req;
    logic [CHAR_W-1:0]  ram_q;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic               full;
    logic [LEN_W-1:0]   avail;
    logic [LEN_W-1:0]   clamp_n;
    logic [LEN_W-1:0]   view_n;
    logic [ADDR_W-1:0]  src_addr, dst_addr;
    t_out               n_res;
    t_out               view_res;

    gbte_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_q)
    );

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = out_free && (r_state == ST_VPUT || r_state == ST_DONE);
    assign full     = (r_left + r_right) == LEN_W'(DEPTH);

    assign avail   = (i_in_data.kind == KIND_MOVE_RIGHT) ? r_right : r_left;
    assign clamp_n = (CMP_W'(i_in_data.count) < CMP_W'(avail))
                   ? LEN_W'(i_in_data.count) : avail;
    assign view_n  = (r_left < LEN_W'(VIEW_LEN)) ? r_left : LEN_W'(VIEW_LEN);

    always_comb begin
        n_res          = '0;
        n_res.accepted = !((i_in_data.kind == KIND_INSERT) && full);
        n_res.last     = 1'b1;
        if (i_in_data.kind == KIND_DELETE) begin
            n_res.deleted = CNT_W'(clamp_n);
        end
        view_res          = '0;
        view_res.accepted = 1'b1;
        view_res.char_out = ram_q;
        view_res.has_char = 1'b1;
        view_res.last     = (r_vcnt == VW_W'(1));
    end

    // gap copy addresses; left move: left-1 -> top of gap, right move reverse
    always_comb begin
        if (r_dir_right) begin
            src_addr = ADDR_W'(LEN_W'(DEPTH) - r_right);
            dst_addr = ADDR_W'(r_left);
        end else begin
            src_addr = ADDR_W'(r_left - 1'b1);
            dst_addr = ADDR_W'(LEN_W'(DEPTH) - r_right - 1'b1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (i_in_data.kind)
                        KIND_INSERT, KIND_DELETE: n_state = ST_DONE;
                        default:                  n_state = ST_MREAD;
                    endcase
                end
            end
            ST_MREAD:  n_state = (r_n == '0) ? ST_VSTART : ST_MWRITE;
            ST_MWRITE: n_state = ST_MREAD;
            ST_VSTART: n_state = (view_n == '0) ? ST_DONE : ST_VREAD;
            ST_VREAD:  n_state = ST_VPUT;
            ST_VPUT: begin
                if (out_free) begin
                    n_state = (r_vcnt == VW_W'(1)) ? ST_IDLE : ST_VREAD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        ram_req.en    = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.addr  = r_vaddr;
        ram_req.wdata = ram_q;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                ram_req.en    = in_xfer && (i_in_data.kind == KIND_INSERT) && !full;
                ram_req.we    = 1'b1;
                ram_req.addr  = ADDR_W'(r_left);
                ram_req.wdata = i_in_data.char_in;
            end
            ST_MREAD: begin
                ram_req.en   = (r_n != '0);
                ram_req.addr = src_addr;
            end
            ST_MWRITE: begin
                ram_req.en   = 1'b1;
                ram_req.we   = 1'b1;
                ram_req.addr = dst_addr;
            end
            ST_VREAD: begin
                ram_req.en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_right     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_res       <= n_res;
                        r_n         <= clamp_n;
                        r_dir_right <= (i_in_data.kind == KIND_MOVE_RIGHT);
                        unique case (i_in_data.kind)
                            KIND_INSERT: begin
                                if (!full) begin
                                    r_left <= r_left + 1'b1;
                                end
                            end
                            KIND_DELETE: begin
                                r_left <= r_left - clamp_n;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MWRITE: begin
                    r_n <= r_n - 1'b1;
                    if (r_dir_right) begin
                        r_left  <= r_left + 1'b1;
                        r_right <= r_right - 1'b1;
                    end else begin
                        r_left  <= r_left - 1'b1;
                        r_right <= r_right + 1'b1;
                    end
                end
                ST_VSTART: begin
                    r_vaddr <= ADDR_W'(r_left - view_n);
                    r_vcnt  <= VW_W'(view_n);
                end
                ST_VPUT: begin
                    if (out_free) begin
                        r_out   <= view_res;
                        r_vaddr <= r_vaddr + 1'b1;
                        r_vcnt  <= r_vcnt - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out <= r_res;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((LEN_W+1)'(r_left) + (LEN_W+1)'(r_right)) <= (LEN_W+1)'(DEPTH))
        else $error("gap buffer lengths exceed depth");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MWRITE) |-> $past(r_state == ST_MREAD))
        else $error("gap copy write without preceding read");

    a_no_write_in_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VREAD || r_state == ST_VPUT) |-> !(ram_req.en && ram_req.we))
        else $error("memory written during view readout");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.kind == KIND_DELETE) |=> (r_left <= $past(r_left)))
        else $error("delete grew left side");
`endif

endmodule

### rtl/gbte_ram.sv
module gbte_ram
    import gbte_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### bench/tb.sv
class editor_scoreboard;
    logic [7:0]     text [gbte_pkg::DEPTH];
    int unsigned    left_len;
    int unsigned    right_len;
    gbte_pkg::t_out due_results [$];
    int             errors;

    function new();
        left_len  = 0;
        right_len = 0;
        errors    = 0;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function string fmt(gbte_pkg::t_out r);
        return $sformatf("acc=%0d del=%0d ch=%02h has=%0d last=%0d",
                         r.accepted, r.deleted, r.char_out, r.has_char, r.last);
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    function void push_result(logic acc, logic [10:0] del, logic [7:0] ch,
                              logic has, logic fin);
        gbte_pkg::t_out r;
        r.accepted = acc;
        r.deleted  = del;
        r.char_out = ch;
        r.has_char = has;
        r.last     = fin;
        due_results = {due_results, r};
    endfunction

    // last up to VIEW_LEN characters left of the cursor, oldest first
    function void push_view();
        int unsigned v;
        v = (left_len < gbte_pkg::VIEW_LEN) ? left_len : gbte_pkg::VIEW_LEN;
        if (v == 0) begin
            push_result(1'b1, '0, '0, 1'b0, 1'b1);
        end else begin
            for (int unsigned i = 0; i < v; i++) begin
                push_result(1'b1, '0, text[left_len - v + i], 1'b1, i + 1 == v);
            end
        end
    endfunction

    function void apply_edit(gbte_pkg::t_in cmd);
        int unsigned n;
        case (cmd.kind)
            gbte_pkg::KIND_INSERT: begin
                if (left_len + right_len >= gbte_pkg::DEPTH) begin
                    push_result(1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                    text[left_len] = cmd.char_in;
                    left_len++;
                    push_result(1'b1, '0, '0, 1'b0, 1'b1);
                end
            end
            gbte_pkg::KIND_DELETE: begin
                n = (cmd.count < left_len) ? cmd.count : left_len;
                left_len -= n;
                push_result(1'b1, 11'(n), '0, 1'b0, 1'b1);
            end
            gbte_pkg::KIND_MOVE_LEFT: begin
                n = (cmd.count < left_len) ? cmd.count : left_len;
                for (int unsigned i = 0; i < n; i++) begin
                    text[gbte_pkg::DEPTH - right_len - 1] = text[left_len - 1];
                    left_len--;
                    right_len++;
                end
                push_view();
            end
            default: begin
                n = (cmd.count < right_len) ? cmd.count : right_len;
                for (int unsigned i = 0; i < n; i++) begin
                    text[left_len] = text[gbte_pkg::DEPTH - right_len];
                    left_len++;
                    right_len--;
                end
                push_view();
            end
        endcase
    endfunction

    task check_result(gbte_pkg::t_out got);
        gbte_pkg::t_out want;
        if (due_results.size() == 0) begin
            report({"result with nothing pending: ", fmt(got)});
            return;
        end
        want = due_results.pop_front();
        if (got.accepted !== want.accepted || got.deleted !== want.deleted ||
            got.char_out !== want.char_out || got.has_char !== want.has_char ||
            got.last !== want.last) begin
            report({"got ", fmt(got), " want ", fmt(want)});
        end
    endtask
endclass

module tb;
    import gbte_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_BEAT
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    editor_scoreboard sb;
    int       idle_cycles;
    int       burst_left;
    t_rx_mode rx_mode;
    int       rx_hold;
    int       rx_phase;

    gap_buffer_text_editor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // receiver: stall pattern is redrawn whenever rx_hold runs out
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_hold <= $urandom_range(40, 300);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_FREE:  i_out_ready <= 1'b1;
            RX_LIGHT: i_out_ready <= ($urandom_range(0, 9) < 7);
            RX_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:  i_out_ready <= ((rx_phase % 7) < 2);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // one command transfer; the sender may idle between bursts
    task automatic send_cmd(input t_kind k, input logic [7:0] ch, input logic [10:0] cnt);
        t_in cmd;
        int  gap;
        cmd.kind    = k;
        cmd.char_in = ch;
        cmd.count   = cnt;
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        sb.apply_edit(cmd);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // hold off the sender until all results are back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [10:0] pick_count(int unsigned avail);
        int s;
        s = $urandom_range(0, 19);
        if (s == 0) return 11'($urandom_range(1024, 2047));
        if (s < 3)  return 11'(avail + $urandom_range(0, 3));
        if (s < 5)  return '0;
        return 11'($urandom_range(1, 12));
    endfunction

    task automatic run_directed();
        send_cmd(KIND_MOVE_LEFT, 8'h00, 11'd0);      // empty view
        send_cmd(KIND_MOVE_RIGHT, 8'hff, 11'd5);
        send_cmd(KIND_DELETE, 8'h00, 11'd3);         // nothing to delete
        send_cmd(KIND_INSERT, 8'h00, 11'd0);         // zero byte is plain text
        send_cmd(KIND_INSERT, 8'hff, 11'd2047);
        send_cmd(KIND_INSERT, 8'h55, 11'd0);
        send_cmd(KIND_INSERT, 8'haa, 11'd0);
        for (int i = 0; i < 8; i++) send_cmd(KIND_INSERT, 8'(8'h61 + i), 11'd0);
        send_cmd(KIND_MOVE_LEFT, 8'h00, 11'd0);      // view without moving
        send_cmd(KIND_MOVE_LEFT, 8'h00, 11'd3);
        send_cmd(KIND_MOVE_LEFT, 8'h00, 11'd2047);   // clamps to left side
        send_cmd(KIND_MOVE_RIGHT, 8'h00, 11'd1);
        send_cmd(KIND_MOVE_RIGHT, 8'h00, 11'd1024);  // clamps to right side
        send_cmd(KIND_DELETE, 8'h00, 11'd0);
        send_cmd(KIND_DELETE, 8'h00, 11'd2);
        send_cmd(KIND_DELETE, 8'h00, 11'd2047);
        send_cmd(KIND_MOVE_RIGHT, 8'h00, 11'd0);
    endtask

    task automatic run_random(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_cmd(KIND_INSERT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            else if (r < 60)
                send_cmd(KIND_DELETE, 8'($urandom), pick_count(sb.left_len));
            else if (r < 80)
                send_cmd(KIND_MOVE_LEFT, 8'($urandom), pick_count(sb.left_len));
            else
                send_cmd(KIND_MOVE_RIGHT, 8'($urandom), pick_count(sb.right_len));
        end
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        idle_cycles = 0;
        burst_left  = 1;
        rx_mode     = RX_FREE;
        rx_hold     = 0;
        rx_phase    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain();
        run_random(175);
        drain();
        run_random(175);
        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### gap_buffer_text_editor.f
rtl/gbte_pkg.sv
rtl/gbte_ram.sv
rtl/gap_buffer_text_editor.sv
bench/tb.sv
